[rtl/tss_pkg.sv]
package tss_pkg;

   localparam int TABLE_SLOTS_DEF = 16;
   localparam int NEEDLE_MAX_DEF  = 32;
   localparam int VALUE_MAX       = 4;

   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   localparam logic [2:0] FN_TABLE = 3'd0;
   localparam logic [2:0] FN_NBYTE = 3'd1;
   localparam logic [2:0] FN_NEND  = 3'd2;
   localparam logic [2:0] FN_HBYTE = 3'd3;
   localparam logic [2:0] FN_HEND  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_NEXT, ST_SCAN, ST_EMIT, ST_MSTART, ST_MRUN, ST_MWR, ST_RESP
   } state_type;

   typedef struct packed {
      logic [31:0] key;
      logic [2:0]  key_len;
      logic [31:0] value;
      logic [2:0]  value_len;
   } slot_type;

   typedef struct packed {
      logic        done;
      logic [31:0] chr;
      logic [2:0]  cnt;
      logic [2:0]  expect_len;
   } feed_type;

   function automatic logic low_eq(logic [31:0] a, logic [31:0] b, logic [2:0] n);
      logic [31:0] m;
      case (n)
         3'd1:    m = 32'h0000_00FF;
         3'd2:    m = 32'h0000_FFFF;
         3'd3:    m = 32'h00FF_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return (a & m) == (b & m);
   endfunction

endpackage

[rtl/tss_ram.sv]
module tss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/tss_utf8.sv]
module tss_utf8 (
   input  logic [31:0]       pend_char,
   input  logic [2:0]        pend_cnt,
   input  logic [2:0]        pend_exp,
   input  logic [7:0]        data_byte,
   output tss_pkg::feed_type feed
);
   import tss_pkg::*;

   logic [2:0]  cnt_new;

   always_comb begin
      feed = '0;
      if (pend_cnt == 3'd0) begin
         if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
            feed.expect_len = 3'd2;
         end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
            feed.expect_len = 3'd3;
         end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
            feed.expect_len = 3'd4;
         end else begin
            feed.expect_len = 3'd1;
         end
         feed.chr = {24'd0, data_byte};
      end else begin
         feed.expect_len = pend_exp;
         feed.chr = pend_char | ({24'd0, data_byte} << {pend_cnt[1:0], 3'd0});
      end
      cnt_new = pend_cnt + 3'd1;
      feed.cnt = cnt_new;
      feed.done = cnt_new >= feed.expect_len;
   end

endmodule

[rtl/transliterated_substring_search.sv]
// Transliterated substring search over UTF-8 byte streams.
// Input channel req_*: one beat per item. req_func selects table write, needle
// byte, needle end, haystack byte or haystack end. Result channel rsp_*: one
// beat per haystack end carrying rsp_found and rsp_needle_overflow.
// A table write is done on acceptance and leaves the sequencer idle. A byte
// that completes a character, or a flush of a pending partial character,
// starts a lookup that walks the table one slot per cycle through the slot
// RAM up to the first enabled slot whose key matches, then emits its value
// bytes, or the character's own bytes on a miss. Needle bytes are emitted one
// per cycle into the needle RAM; a haystack byte, while no match is seen yet,
// is compared byte by byte with the needle through the needle and window
// RAMs and then written to the window. req_ready is high only while the
// sequencer idles; one item is in work at a time. A haystack end with nothing
// pending goes via ST_NEXT to ST_RESP, which raises rsp_valid and holds the
// result on rsp_* until rsp_ready; a stalled receiver holds the whole block.
// Reset disables all table slots and clears needle, haystack and pending
// character state; table and needle contents are written before use.
module transliterated_substring_search #(
   parameter int TABLE_SLOTS = tss_pkg::TABLE_SLOTS_DEF,
   parameter int NEEDLE_MAX  = tss_pkg::NEEDLE_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic [3:0]  req_entry_index,
   input  logic [31:0] req_entry_key,
   input  logic [2:0]  req_key_length,
   input  logic [31:0] req_entry_value,
   input  logic [2:0]  req_value_length,
   input  logic        req_entry_valid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic        rsp_needle_overflow
);
   import tss_pkg::*;

   localparam int SAW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int SCW = $clog2(TABLE_SLOTS + 1);
   localparam int NAW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
   localparam int NLW = $clog2(NEEDLE_MAX + 1);

   state_type state_ff, state_in;

   logic             slot_en_ff [TABLE_SLOTS];
   logic             slot_en_in [TABLE_SLOTS];
   logic [31:0]      pend_char_ff, pend_char_in;
   logic [2:0]       pend_cnt_ff, pend_cnt_in;
   logic [2:0]       pend_exp_ff, pend_exp_in;
   logic [NLW-1:0]   nlen_ff, nlen_in;
   logic             nraw_ff, nraw_in;
   logic             nclosed_ff, nclosed_in;
   logic             ovf_ff, ovf_in;
   logic [NAW-1:0]   wp_ff, wp_in;
   logic [NLW-1:0]   fill_ff, fill_in;
   logic             hraw_ff, hraw_in;
   logic             match_ff, match_in;
   logic             feed_ff, feed_in;
   logic             report_ff, report_in;
   logic             cvld_ff, cvld_in;
   logic             mvld_ff, mvld_in;

   logic             feed_sink_ff, feed_sink_in;
   logic [7:0]       feed_byte_ff, feed_byte_in;
   logic [31:0]      job_char_ff, job_char_in;
   logic [2:0]       job_n_ff, job_n_in;
   logic             job_sink_ff, job_sink_in;
   logic [SCW-1:0]   sc_ff, sc_in;
   logic [SAW-1:0]   cidx_ff, cidx_in;
   logic [31:0]      emit_data_ff, emit_data_in;
   logic [2:0]       emit_cnt_ff, emit_cnt_in;
   logic [2:0]       k_ff, k_in;
   logic [7:0]       b_ff, b_in;
   logic [NLW-1:0]   mi_ff, mi_in;
   logic [NAW-1:0]   rp_ff, rp_in;
   logic             mlast_ff, mlast_in;

   logic             slot_we;
   logic [SAW-1:0]   slot_waddr, slot_raddr;
   slot_type         slot_wdata, slot_rdata;
   logic             nd_we;
   logic [NAW-1:0]   nd_waddr, nd_raddr;
   logic [7:0]       nd_rdata;
   logic             win_we;
   logic [NAW-1:0]   win_raddr;
   logic [7:0]       win_rdata;

   feed_type         feed;
   logic             accept;
   logic             rsp_take;
   logic [31:0]      idx32;
   logic             idx_ok;
   logic [2:0]       vl_clamp;
   logic             scan_hit, scan_end;
   logic             emit_done;
   logic [7:0]       emit_byte;
   logic [NLW:0]     wp_x, lm1_x, start_x, fill_x;
   logic             m_try, m_eq, m_fail, m_hit;

   assign accept   = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   assign idx32      = 32'(req_entry_index);
   assign idx_ok     = idx32 < TABLE_SLOTS;
   assign slot_waddr = idx32[SAW-1:0];

   always_comb begin
      vl_clamp = req_value_length;
      if (vl_clamp > 3'd4) begin
         vl_clamp = 3'd4;
      end
      if (int'(vl_clamp) > VALUE_MAX) begin
         vl_clamp = 3'(VALUE_MAX);
      end
   end

   assign slot_we    = accept && (req_func == FN_TABLE) && idx_ok;
   assign slot_wdata = '{key: req_entry_key, key_len: req_key_length,
                         value: req_entry_value, value_len: vl_clamp};
   assign slot_raddr = sc_ff[SAW-1:0];

   tss_ram #(.WIDTH($bits(slot_type)), .DEPTH(TABLE_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   assign emit_done = k_ff >= emit_cnt_ff;
   assign emit_byte = emit_data_ff[{k_ff[1:0], 3'd0} +: 8];

   assign nd_we    = (state_ff == ST_EMIT) && !emit_done && job_sink_ff &&
                     (nlen_ff < NLW'(NEEDLE_MAX));
   assign nd_waddr = nlen_ff[NAW-1:0];
   assign nd_raddr = mi_ff[NAW-1:0];

   tss_ram #(.WIDTH(8), .DEPTH(NEEDLE_MAX)) u_needle_ram (
      .clock   (clock),
      .wr_en   (nd_we),
      .wr_addr (nd_waddr),
      .wr_data (emit_byte),
      .rd_addr (nd_raddr),
      .rd_data (nd_rdata)
   );

   assign win_we    = (state_ff == ST_MWR);
   assign win_raddr = rp_ff;

   tss_ram #(.WIDTH(8), .DEPTH(NEEDLE_MAX)) u_window_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (wp_ff),
      .wr_data (b_ff),
      .rd_addr (win_raddr),
      .rd_data (win_rdata)
   );

   tss_utf8 u_utf8 (
      .pend_char (pend_char_ff),
      .pend_cnt  (pend_cnt_ff),
      .pend_exp  (pend_exp_ff),
      .data_byte (feed_byte_ff),
      .feed      (feed)
   );

   assign scan_hit = cvld_ff && slot_en_ff[cidx_ff] && (slot_rdata.key_len == job_n_ff) &&
                     low_eq(slot_rdata.key, job_char_ff, job_n_ff);
   assign scan_end = cvld_ff && (cidx_ff == SAW'(TABLE_SLOTS - 1));

   assign wp_x    = (NLW+1)'(wp_ff);
   assign lm1_x   = (NLW+1)'(nlen_ff) - (NLW+1)'(1);
   assign fill_x  = (NLW+1)'(fill_ff);
   assign start_x = (wp_x >= lm1_x) ? wp_x - lm1_x : wp_x + (NLW+1)'(NEEDLE_MAX) - lm1_x;
   assign m_try   = !match_ff && (nlen_ff != '0) && (fill_x >= lm1_x);
   assign m_eq    = nd_rdata == (mlast_ff ? b_ff : win_rdata);
   assign m_fail  = mvld_ff && !m_eq;
   assign m_hit   = mvld_ff && m_eq && mlast_ff;

   // datapath next values
   always_comb begin
      slot_en_in   = slot_en_ff;
      pend_char_in = pend_char_ff;
      pend_cnt_in  = pend_cnt_ff;
      pend_exp_in  = pend_exp_ff;
      nlen_in      = nlen_ff;
      nraw_in      = nraw_ff;
      nclosed_in   = nclosed_ff;
      ovf_in       = ovf_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      hraw_in      = hraw_ff;
      match_in     = match_ff;
      feed_in      = feed_ff;
      report_in    = report_ff;
      cvld_in      = 1'b0;
      mvld_in      = 1'b0;
      feed_sink_in = feed_sink_ff;
      feed_byte_in = feed_byte_ff;
      job_char_in  = job_char_ff;
      job_n_in     = job_n_ff;
      job_sink_in  = job_sink_ff;
      sc_in        = sc_ff;
      cidx_in      = cidx_ff;
      emit_data_in = emit_data_ff;
      emit_cnt_in  = emit_cnt_ff;
      k_in         = k_ff;
      b_in         = b_ff;
      mi_in        = mi_ff;
      rp_in        = rp_ff;
      mlast_in     = mlast_ff;
      sc_in        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               feed_byte_in = req_data_byte;
               case (req_func)
                  FN_TABLE: begin
                     if (idx_ok) begin
                        slot_en_in[slot_waddr] = req_entry_valid;
                     end
                  end
                  FN_NBYTE: begin
                     if (nclosed_ff) begin
                        pend_cnt_in = '0;
                        pend_exp_in = '0;
                        nlen_in     = '0;
                        nclosed_in  = 1'b0;
                        ovf_in      = 1'b0;
                        fill_in     = '0;
                        hraw_in     = 1'b0;
                        match_in    = 1'b0;
                     end
                     nraw_in      = 1'b1;
                     feed_in      = 1'b1;
                     feed_sink_in = 1'b1;
                  end
                  FN_NEND, FN_HBYTE, FN_HEND: begin
                     if (!nclosed_ff) begin
                        nclosed_in = 1'b1;
                        fill_in    = '0;
                        hraw_in    = 1'b0;
                        match_in   = 1'b0;
                     end
                     if (pend_cnt_ff != 3'd0 &&
                         (!nclosed_ff || req_func == FN_NEND || req_func == FN_HEND)) begin
                        job_char_in = pend_char_ff;
                        job_n_in    = pend_cnt_ff;
                        job_sink_in = !nclosed_ff || req_func == FN_NEND;
                        pend_cnt_in = '0;
                        pend_exp_in = '0;
                     end
                     if (req_func == FN_HBYTE) begin
                        hraw_in      = 1'b1;
                        feed_in      = 1'b1;
                        feed_sink_in = 1'b0;
                     end
                     if (req_func == FN_HEND) begin
                        report_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_NEXT: begin
            if (feed_ff) begin
               feed_in = 1'b0;
               if (feed.done) begin
                  job_char_in = feed.chr;
                  job_n_in    = feed.cnt;
                  job_sink_in = feed_sink_ff;
                  pend_cnt_in = '0;
                  pend_exp_in = '0;
               end else begin
                  pend_char_in = feed.chr;
                  pend_cnt_in  = feed.cnt;
                  pend_exp_in  = feed.expect_len;
               end
            end
         end
         ST_SCAN: begin
            sc_in = sc_ff;
            if (sc_ff < SCW'(TABLE_SLOTS)) begin
               cvld_in = 1'b1;
               cidx_in = sc_ff[SAW-1:0];
               sc_in   = sc_ff + SCW'(1);
            end
            k_in = '0;
            if (scan_hit) begin
               emit_data_in = slot_rdata.value;
               emit_cnt_in  = slot_rdata.value_len;
            end else begin
               emit_data_in = job_char_ff;
               emit_cnt_in  = job_n_ff;
            end
         end
         ST_EMIT: begin
            if (!emit_done) begin
               if (job_sink_ff) begin
                  if (nlen_ff < NLW'(NEEDLE_MAX)) begin
                     nlen_in = nlen_ff + NLW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  k_in = k_ff + 3'd1;
               end else begin
                  b_in = emit_byte;
               end
            end
         end
         ST_MSTART: begin
            mi_in = '0;
            rp_in = start_x[NAW-1:0];
         end
         ST_MRUN: begin
            if (mi_ff < nlen_ff) begin
               mvld_in  = 1'b1;
               mlast_in = mi_ff == nlen_ff - NLW'(1);
               mi_in    = mi_ff + NLW'(1);
               rp_in    = (rp_ff == NAW'(NEEDLE_MAX - 1)) ? '0 : rp_ff + NAW'(1);
            end
            if (m_hit) begin
               match_in = 1'b1;
            end
         end
         ST_MWR: begin
            wp_in = (wp_ff == NAW'(NEEDLE_MAX - 1)) ? '0 : wp_ff + NAW'(1);
            if (fill_ff < NLW'(NEEDLE_MAX - 1)) begin
               fill_in = fill_ff + NLW'(1);
            end
            k_in = k_ff + 3'd1;
         end
         ST_RESP: begin
            if (rsp_take) begin
               report_in = 1'b0;
               fill_in   = '0;
               hraw_in   = 1'b0;
               match_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FN_NBYTE: state_in = ST_NEXT;
                  FN_NEND, FN_HBYTE, FN_HEND: begin
                     if (pend_cnt_ff != 3'd0 &&
                         (!nclosed_ff || req_func == FN_NEND || req_func == FN_HEND)) begin
                        state_in = ST_SCAN;
                     end else if (req_func != FN_NEND) begin
                        state_in = ST_NEXT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_NEXT: begin
            if (feed_ff) begin
               state_in = feed.done ? ST_SCAN : ST_IDLE;
            end else if (report_ff) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_done) begin
               state_in = ST_NEXT;
            end else if (!job_sink_ff) begin
               state_in = ST_MSTART;
            end
         end
         ST_MSTART: state_in = m_try ? ST_MRUN : ST_MWR;
         ST_MRUN: begin
            if (m_fail || m_hit) begin
               state_in = ST_MWR;
            end
         end
         ST_MWR:  state_in = ST_EMIT;
         ST_RESP: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_found = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!nraw_ff) begin
               rsp_found = 1'b1;
            end else if (!hraw_ff) begin
               rsp_found = 1'b0;
            end else if (nlen_ff == '0) begin
               rsp_found = 1'b1;
            end else begin
               rsp_found = match_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_needle_overflow = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_en_ff   <= '{default: 1'b0};
         pend_char_ff <= '0;
         pend_cnt_ff  <= '0;
         pend_exp_ff  <= '0;
         nlen_ff      <= '0;
         nraw_ff      <= 1'b0;
         nclosed_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         hraw_ff      <= 1'b0;
         match_ff     <= 1'b0;
         feed_ff      <= 1'b0;
         report_ff    <= 1'b0;
         cvld_ff      <= 1'b0;
         mvld_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_en_ff   <= slot_en_in;
         pend_char_ff <= pend_char_in;
         pend_cnt_ff  <= pend_cnt_in;
         pend_exp_ff  <= pend_exp_in;
         nlen_ff      <= nlen_in;
         nraw_ff      <= nraw_in;
         nclosed_ff   <= nclosed_in;
         ovf_ff       <= ovf_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         hraw_ff      <= hraw_in;
         match_ff     <= match_in;
         feed_ff      <= feed_in;
         report_ff    <= report_in;
         cvld_ff      <= cvld_in;
         mvld_ff      <= mvld_in;
      end
   end

   always_ff @(posedge clock) begin
      feed_sink_ff <= feed_sink_in;
      feed_byte_ff <= feed_byte_in;
      job_char_ff  <= job_char_in;
      job_n_ff     <= job_n_in;
      job_sink_ff  <= job_sink_in;
      sc_ff        <= sc_in;
      cidx_ff      <= cidx_in;
      emit_data_ff <= emit_data_in;
      emit_cnt_ff  <= emit_cnt_in;
      k_ff         <= k_in;
      b_ff         <= b_in;
      mi_ff        <= mi_in;
      rp_ff        <= rp_in;
      mlast_ff     <= mlast_in;
   end

   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("result beat while taking input");

   a_nlen_max: assert property (@(posedge clock) disable iff (reset)
      nlen_ff <= NLW'(NEEDLE_MAX)) else $error("needle length past store");

   a_pend_short: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff != 3'd0 |-> pend_cnt_ff < pend_exp_ff)
      else $error("pending character not flushed");

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NLW'(NEEDLE_MAX - 1)) else $error("window fill past window");

endmodule
